// ----- rtl/nts_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nts_pkg
// Shared constants, codes and types of the nearest texture sampler.
// ---------------------------------------------------------------------------
package nts_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_SIZE    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SZ_W        = $clog2(MAX_SIZE + 1);
    localparam int XW          = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW          = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int FRAC_W      = 16;
    localparam int TEXEL_W     = 32;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    // channel layouts
    localparam logic [2:0] CH_GRAY       = 3'd1;
    localparam logic [2:0] CH_GRAY_ALPHA = 3'd2;
    localparam logic [2:0] CH_RGB        = 3'd3;
    localparam logic [2:0] CH_RGBA       = 3'd4;

    // item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE_X,
        ST_SCALE_Y,
        ST_READ,
        ST_UNPACK
    } state_t;

endpackage

// ----- rtl/nts_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module nts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/nts_scale_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nts_scale_unit
// Shared coordinate scaler: floor(size * (1 - frac)), clamped to size-1.
// ---------------------------------------------------------------------------
module nts_scale_unit (
    input  logic                      clk,
    input  logic                      load,
    input  logic [nts_pkg::FRAC_W-1:0] frac,
    input  logic [nts_pkg::SZ_W-1:0]  size,
    output logic [nts_pkg::SZ_W-1:0]  pos
);

    localparam int FLIP_W = nts_pkg::FRAC_W + 1;
    localparam int PROD_W = nts_pkg::SZ_W + FLIP_W;

    logic [FLIP_W-1:0]        flip;
    logic [PROD_W-1:0]        product_reg;
    logic [nts_pkg::SZ_W-1:0] size_reg;
    logic [nts_pkg::SZ_W:0]   scaled;
    logic [nts_pkg::SZ_W:0]   limit;

    // one minus the fraction, 1..65536
    assign flip = {1'b1, {nts_pkg::FRAC_W{1'b0}}} - {1'b0, frac};

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= PROD_W'(size) * PROD_W'(flip);
            size_reg    <= size;
        end
    end

    assign scaled = product_reg[PROD_W-1:nts_pkg::FRAC_W];
    assign limit  = {1'b0, size_reg} - (nts_pkg::SZ_W + 1)'(1);

    always_comb
    begin
        if (scaled > limit)
        begin
            pos = limit[nts_pkg::SZ_W-1:0];
        end
        else
        begin
            pos = scaled[nts_pkg::SZ_W-1:0];
        end
    end

endmodule

// ----- rtl/nearest_texture_sampler_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_texture_sampler_top
// Nearest-neighbour texture sampler with repeat wrap over a texel store.
// ---------------------------------------------------------------------------
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  s_tuser kind, s_tdata coords/texel
//  m_*      out        m_tvalid/m_tready  m_tdata rgba unorm8
//  cfg_*    in         cfg_wr_en          cfg_index, cfg_wdata
//
//  a write item is stored when accepted; a sample item makes two passes
//  through the shared scaling multiplier (x then y), one store read, unpack
//  the sampler takes a new item only when idle; a result waits in the output
//  register, and a sample finishing while it is still held stalls in unpack
//  reset clears the control state and loads 256 x 256, rgba; the texel store
//  is not cleared and must be written before it is sampled
// ---------------------------------------------------------------------------
module nearest_texture_sampler_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [95:0]                       s_tdata,  // write_x, write_y, texel_bytes, u_coord, v_coord
    input  logic                              s_tuser,  // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // red, green, blue, alpha
    input  logic                              cfg_wr_en,
    input  logic [nts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nts_pkg::CFG_W-1:0]         cfg_wdata
);

    nts_pkg::state_t state_reg, state_next;

    logic [8:0] tex_width_reg;
    logic [8:0] tex_height_reg;
    logic [2:0] channel_count_reg;

    logic [7:0]                  write_x;
    logic [7:0]                  write_y;
    logic [nts_pkg::TEXEL_W-1:0] texel_bytes;
    logic [23:0]                 u_coord;
    logic [23:0]                 v_coord;

    logic [nts_pkg::FRAC_W-1:0] u_frac_reg;
    logic [nts_pkg::FRAC_W-1:0] v_frac_reg;
    logic [nts_pkg::XW-1:0]     x_reg;

    logic [nts_pkg::SZ_W-1:0] w_eff;
    logic [nts_pkg::SZ_W-1:0] h_eff;

    logic                       unit_load;
    logic [nts_pkg::FRAC_W-1:0] unit_frac;
    logic [nts_pkg::SZ_W-1:0]   unit_size;
    logic [nts_pkg::SZ_W-1:0]   unit_pos;

    logic                        accept;
    logic                        wr_en;
    logic [31:0]                 wr_addr_full;
    logic [31:0]                 rd_addr_full;
    logic                        rd_en;
    logic [nts_pkg::TEXEL_W-1:0] rd_data;

    logic        out_load;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [31:0] unpacked;

    assign write_x     = s_tdata[7:0];
    assign write_y     = s_tdata[15:8];
    assign texel_bytes = s_tdata[47:16];
    assign u_coord     = s_tdata[71:48];
    assign v_coord     = s_tdata[95:72];

    assign accept = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg     <= 9'd256;
            tex_height_reg    <= 9'd256;
            channel_count_reg <= nts_pkg::CH_RGBA;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                nts_pkg::CFG_TEX_WIDTH:     tex_width_reg     <= cfg_wdata;
                nts_pkg::CFG_TEX_HEIGHT:    tex_height_reg    <= cfg_wdata;
                nts_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_wdata[2:0];
                default:                    ;
            endcase
        end
    end

    // zero reads as one, oversize saturates to the store size
    always_comb
    begin
        if (tex_width_reg == 9'd0)
        begin
            w_eff = nts_pkg::SZ_W'(1);
        end
        else if (32'(tex_width_reg) > 32'(nts_pkg::MAX_WIDTH))
        begin
            w_eff = nts_pkg::SZ_W'(nts_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = nts_pkg::SZ_W'(tex_width_reg);
        end

        if (tex_height_reg == 9'd0)
        begin
            h_eff = nts_pkg::SZ_W'(1);
        end
        else if (32'(tex_height_reg) > 32'(nts_pkg::MAX_HEIGHT))
        begin
            h_eff = nts_pkg::SZ_W'(nts_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = nts_pkg::SZ_W'(tex_height_reg);
        end
    end

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nts_pkg::ST_IDLE:
            begin
                if (accept && (s_tuser == nts_pkg::KIND_SAMPLE))
                begin
                    state_next = nts_pkg::ST_SCALE_X;
                end
            end
            nts_pkg::ST_SCALE_X: state_next = nts_pkg::ST_SCALE_Y;
            nts_pkg::ST_SCALE_Y: state_next = nts_pkg::ST_READ;
            nts_pkg::ST_READ:    state_next = nts_pkg::ST_UNPACK;
            nts_pkg::ST_UNPACK:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = nts_pkg::ST_IDLE;
                end
            end
            default:             state_next = nts_pkg::ST_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        s_tready  = 1'b0;
        unit_load = 1'b0;
        unit_frac = u_frac_reg;
        unit_size = w_eff;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            nts_pkg::ST_IDLE:    s_tready = 1'b1;
            nts_pkg::ST_SCALE_X: unit_load = 1'b1;
            nts_pkg::ST_SCALE_Y:
            begin
                unit_load = 1'b1;
                unit_frac = v_frac_reg;
                unit_size = h_eff;
            end
            nts_pkg::ST_READ:    rd_en = 1'b1;
            nts_pkg::ST_UNPACK:  out_load = !out_valid_reg || m_tready;
            default:             ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sample coordinates; only the fraction matters under repeat wrap
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_frac_reg <= u_coord[nts_pkg::FRAC_W-1:0];
            v_frac_reg <= v_coord[nts_pkg::FRAC_W-1:0];
        end
        if (state_reg == nts_pkg::ST_SCALE_Y)
        begin
            x_reg <= unit_pos[nts_pkg::XW-1:0];
        end
    end

    nts_scale_unit u_scale (
        .clk   (clk),
        .load  (unit_load),
        .frac  (unit_frac),
        .size  (unit_size),
        .pos   (unit_pos)
    );

    // texel store, row stride is the store width
    assign wr_en = accept && (s_tuser == nts_pkg::KIND_WRITE)
                   && (32'(write_x) < 32'(nts_pkg::MAX_WIDTH))
                   && (32'(write_y) < 32'(nts_pkg::MAX_HEIGHT));
    assign wr_addr_full = 32'(write_y) * 32'(nts_pkg::MAX_WIDTH) + 32'(write_x);
    assign rd_addr_full = 32'(unit_pos[nts_pkg::YW-1:0]) * 32'(nts_pkg::MAX_WIDTH)
                          + 32'(x_reg);

    nts_ram #(
        .WIDTH (nts_pkg::TEXEL_W),
        .DEPTH (nts_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_full[nts_pkg::ADDR_W-1:0]),
        .wr_data (texel_bytes),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_full[nts_pkg::ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // unpack by channel layout; missing colour reads 0, missing alpha 255
    always_comb
    begin
        case (channel_count_reg)
            nts_pkg::CH_GRAY:       unpacked = {8'hFF, 16'h0000, rd_data[7:0]};
            nts_pkg::CH_GRAY_ALPHA: unpacked = {rd_data[15:8], 16'h0000, rd_data[7:0]};
            nts_pkg::CH_RGB:        unpacked = {8'hFF, rd_data[23:0]};
            nts_pkg::CH_RGBA:       unpacked = rd_data;
            default:                unpacked = {8'hFF, 24'h000000};
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= unpacked;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
